// ----- design/cida_pkg.sv -----
// Shared types and constants for the card ID allowlist with enrollment.
// Holds the opcode, status and controller state codes and the result record.
// Depends on nothing; cida_ctrl and the top level import it.
`default_nettype none

package cida_pkg;

   // Widths fixed by the transaction fields.
   localparam int ID_LOW_W  = 64;
   localparam int ID_HIGH_W = 16;
   localparam int ID_W      = ID_LOW_W + ID_HIGH_W;
   localparam int LEN_W     = 4;
   localparam int WIN_W     = 32;
   localparam int CNT_OUT_W = 5;

   // Input transaction kinds.
   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CARD   = 3'd1,
      OP_START  = 3'd2,
      OP_CANCEL = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_TAKE   = 3'd5
   } opcode_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_GRANTED  = 3'd1,
      STAT_DENIED   = 3'd2,
      STAT_ENROLLED = 3'd3,
      STAT_PRESENT  = 3'd4,
      STAT_FULL     = 3'd5,
      STAT_IGNORED  = 3'd6
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_APPLY
   } state_type;

   // One result transaction.
   typedef struct packed {
      status_type             status;
      logic                   unlock;
      logic                   event_flag;
      logic                   enroll_active;
      logic [CNT_OUT_W-1:0]   entry_count;
   } rsp_type;

   // Byte mask that keeps the first len bytes of an ID.
   function automatic logic [ID_W-1:0] id_mask(input logic [LEN_W-1:0] len);
      logic [ID_W-1:0] m;
      m = '0;
      for (int b = 0; b < ID_W / 8; b++) begin
         if (LEN_W'(b) < len) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- design/cida_store.sv -----
// ID table memory: one write port and one read port with registered read data.
// Each entry holds a stored ID length above the masked ID bytes.
// Depends on nothing outside this file.
`default_nettype none

module cida_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 84
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/cida_ctrl.sv -----
// Controller: takes one transaction, scans the ID table for a match, then
// applies the enroll, timer and event state and produces the result.
// Depends on cida_pkg; drives the ports of cida_store.
`default_nettype none

module cida_ctrl #(
   parameter int TABLE_DEPTH  = 16,
   parameter int MAX_ID_BYTES = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input transaction
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cida_pkg::opcode_type          req_opcode,
   input  wire logic [cida_pkg::ID_LOW_W-1:0] req_id_low,
   input  wire logic [cida_pkg::ID_HIGH_W-1:0] req_id_high,
   input  wire logic [cida_pkg::LEN_W-1:0]    req_id_length,
   input  wire logic [cida_pkg::WIN_W-1:0]    req_window_ticks,
   // Result transaction
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output cida_pkg::rsp_type                  res,
   // Table memory
   output logic                               rd_en,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
   input  wire logic [8*MAX_ID_BYTES+cida_pkg::LEN_W-1:0] rd_data,
   output logic                               wr_en,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
   output logic [8*MAX_ID_BYTES+cida_pkg::LEN_W-1:0] wr_data
);

   import cida_pkg::*;

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int IDW = 8 * MAX_ID_BYTES;
   localparam int KW  = IDW + LEN_W;

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             mode_ff, mode_in;
   logic [WIN_W-1:0] rem_ff, rem_in;
   logic             latch_ff, latch_in;
   logic [CW-1:0]    scan_idx_ff, scan_idx_in;
   logic             cmp_pend_ff;
   logic             hit_ff;

   opcode_type       op_ff;
   logic [KW-1:0]    key_ff;
   logic [WIN_W-1:0] win_ff;
   logic             card_ok_ff;

   logic             accept;
   logic             push;
   logic             match;
   logic             card_ok;
   logic [ID_W-1:0]  masked_id;
   logic             store_new;
   logic [CW-1:0]    scan_nxt;

   assign accept   = req_valid && req_ready;
   assign push     = res_valid && res_ready;
   assign match    = cmp_pend_ff && (rd_data == key_ff);
   assign card_ok  = (req_id_length != '0) && (req_id_length <= LEN_W'(MAX_ID_BYTES));
   assign masked_id = {req_id_high, req_id_low} & id_mask(req_id_length);
   assign scan_nxt = scan_idx_ff + CW'(1);

   // Capture the transaction, with the ID reduced to its used bytes.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_opcode;
         key_ff     <= {req_id_length, masked_id[IDW-1:0]};
         win_ff     <= req_window_ticks;
         card_ok_ff <= card_ok;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_CARD && card_ok && cnt_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_SCAN: begin
            if (scan_nxt == cnt_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  rd_en     = 1'b1;
         ST_WAIT:  ;
         ST_APPLY: res_valid = 1'b1;
         default:  ;
      endcase
   end

   // Scan address walks the stored entries from zero.
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (accept) begin
         scan_idx_in = '0;
      end else if (rd_en) begin
         scan_idx_in = scan_nxt;
      end
   end

   assign rd_addr = scan_idx_ff[AW-1:0];

   // Decide the result and the next table, enroll and event state.
   always_comb begin
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      rem_in    = rem_ff;
      latch_in  = latch_ff;
      store_new = 1'b0;
      res.status     = STAT_OK;
      res.unlock     = 1'b0;
      res.event_flag = 1'b0;
      case (op_ff)
         OP_TICK: begin
            if (mode_ff) begin
               if (rem_ff == '0) begin
                  mode_in  = 1'b0;
                  latch_in = 1'b1;
               end else begin
                  rem_in = rem_ff - WIN_W'(1);
               end
            end
         end
         OP_CARD: begin
            if (!card_ok_ff) begin
               res.status = STAT_IGNORED;
            end else if (mode_ff) begin
               if (hit_ff) begin
                  res.status = STAT_PRESENT;
               end else if (cnt_ff == CW'(TABLE_DEPTH)) begin
                  res.status = STAT_FULL;
               end else begin
                  res.status = STAT_ENROLLED;
                  store_new  = 1'b1;
                  cnt_in     = cnt_ff + CW'(1);
               end
               mode_in  = 1'b0;
               latch_in = 1'b1;
            end else if (hit_ff) begin
               res.status = STAT_GRANTED;
               res.unlock = 1'b1;
            end else begin
               res.status = STAT_DENIED;
            end
         end
         OP_START: begin
            mode_in = 1'b1;
            rem_in  = win_ff;
         end
         OP_CANCEL: begin
            mode_in  = 1'b0;
            latch_in = 1'b1;
         end
         OP_CLEAR: begin
            cnt_in   = '0;
            mode_in  = 1'b0;
            latch_in = 1'b1;
         end
         OP_TAKE: begin
            res.event_flag = latch_ff;
            latch_in       = 1'b0;
         end
         default: begin
            res.status = STAT_IGNORED;
         end
      endcase
      res.enroll_active = mode_in;
      res.entry_count   = CNT_OUT_W'(cnt_in);
   end

   // A new entry is appended at the current fill count.
   assign wr_en   = push && store_new;
   assign wr_addr = cnt_ff[AW-1:0];
   assign wr_data = key_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         mode_ff     <= 1'b0;
         rem_ff      <= '0;
         latch_ff    <= 1'b0;
         scan_idx_ff <= '0;
         cmp_pend_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         cmp_pend_ff <= rd_en;
         if (accept) begin
            hit_ff <= 1'b0;
         end else if (match) begin
            hit_ff <= 1'b1;
         end
         if (push) begin
            cnt_ff   <= cnt_in;
            mode_ff  <= mode_in;
            rem_ff   <= rem_in;
            latch_ff <= latch_in;
         end
      end
   end

`ifndef SYNTH
   // Appends never pass the table depth and never collide with a scan read.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cnt_ff < CW'(TABLE_DEPTH)) && !rd_en)
      else $error("table write beyond depth or during scan");

   // Only entries below the fill count are ever read.
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (scan_idx_ff < cnt_ff))
      else $error("scan read of an unfilled entry");

   // No compare is still in flight when the result is decided.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> !cmp_pend_ff)
      else $error("result decided before the last compare");

   // The match flag only starts fresh on a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      $past(accept) && !$past(reset) |-> !hit_ff)
      else $error("match flag not cleared on a new transaction");
`endif

endmodule

`default_nettype wire

// ----- design/card_id_allowlist_with_enroll_top.sv -----
// Top level of the card ID allowlist with enrollment window.
// Instantiates cida_ctrl and cida_store and holds the result output register.
// Depends on cida_pkg.
//
// Usage:
// - Input channel req_*: one transaction per command; req_tuser carries the
//   opcode, req_tdata the ID bytes, ID length and enroll window.
// - Result channel rsp_*: exactly one result transaction per input; rsp_tuser
//   carries the status, rsp_tdata the unlock, event and count fields.
// - A presented card with a valid length scans the stored entries one per
//   cycle through the table's single read port, then passes a wait state for
//   the last compare before the apply state. Other commands go from the idle
//   state straight to the apply state. The result is written from the apply
//   state into the output register, which drives rsp_tvalid.
// - One transaction is worked at a time; the next one is taken while the
//   previous result still waits in the output register.
// - When the receiver stalls with a result held, the controller holds its
//   finished result and does not accept further input until it is taken.
// - Reset empties the table count, leaves enroll mode, clears the event
//   latch and drops rsp_tvalid. Table contents need no clearing.
`default_nettype none

module card_id_allowlist_with_enroll_top #(
   parameter int TABLE_DEPTH  = 16,
   parameter int MAX_ID_BYTES = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input: id_low [63:0], id_high [79:64], id_length [83:80],
   //        window_ticks [115:84], zero [119:116]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [119:0] req_tdata,
   // opcode [2:0]
   input  wire logic [2:0]   req_tuser,
   // Result: unlock [0], event_flag [1], enroll_active [2], entry_count [7:3]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,
   // status [2:0]
   output logic [2:0]        rsp_tuser
);

   import cida_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KW = 8 * MAX_ID_BYTES + LEN_W;

   logic          res_valid;
   logic          res_ready;
   rsp_type       res;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_data;

   logic          rsp_vld_ff;
   rsp_type       rsp_ff;

   cida_ctrl #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_ID_BYTES (MAX_ID_BYTES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_opcode       (opcode_type'(req_tuser)),
      .req_id_low       (req_tdata[63:0]),
      .req_id_high      (req_tdata[79:64]),
      .req_id_length    (req_tdata[83:80]),
      .req_window_ticks (req_tdata[115:84]),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   cida_store #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (KW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Output register: takes a result whenever it is empty or being drained.
   assign res_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.entry_count, rsp_ff.enroll_active,
                        rsp_ff.event_flag, rsp_ff.unlock};

endmodule

`default_nettype wire
